// ===== design/smx_pkg.sv =====
// softmax vector unit package: beat types and exp lookup tables
// no dependencies; tables are built at elaboration
`default_nettype none
package smx_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ProbW   = 17;
  localparam int unsigned PosW    = 6;
  localparam int unsigned ExpW    = 17;
  localparam int unsigned SumW    = 23;
  localparam int unsigned IntTabN = 12;
  localparam int unsigned FracTabN = 256;
  localparam int unsigned ExpLimit = 11 * 256;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      end_of_vector;
  } in_t;

  typedef struct packed {
    logic [ProbW-1:0] probability;
    logic [PosW-1:0]  position;
    logic             final_result;
    logic             truncated;
  } out_t;

  typedef logic [ExpW-1:0] int_tab_t [IntTabN];
  typedef logic [ExpW-1:0] frac_tab_t [FracTabN];

  function automatic int_tab_t gen_int_tab();
    int_tab_t t;
    real      r;
    for (int k = 0; k < IntTabN; k++) begin
      r = 65536.0 * $exp(-1.0 * k);
      t[k] = ExpW'($rtoi(r + 0.5));
    end
    return t;
  endfunction

  function automatic frac_tab_t gen_frac_tab();
    frac_tab_t t;
    real       r;
    for (int k = 0; k < FracTabN; k++) begin
      r = 65536.0 * $exp(-1.0 * k / 256.0);
      t[k] = ExpW'($rtoi(r + 0.5));
    end
    return t;
  endfunction

  localparam int_tab_t  IntTab  = gen_int_tab();
  localparam frac_tab_t FracTab = gen_frac_tab();

endpackage
`default_nettype wire

// ===== design/smx_divider.sv =====
// bit-serial restoring divider: round(e*65536/sum), one quotient bit a cycle
// depends on smx_pkg
`default_nettype none
module smx_divider (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [smx_pkg::ExpW-1:0] exp_i,
  input  wire logic [smx_pkg::SumW-1:0] sum_i,
  output logic                          done_o,
  output logic [smx_pkg::ProbW-1:0]     quot_o
);
  import smx_pkg::*;

  localparam int unsigned NumW = ExpW + 16 + 7;

  logic [NumW-1:0]  num;
  logic [SumW-1:0]  rem_q, rem_d;
  logic [ProbW-1:0] sh_q, sh_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [SumW:0]    trial;

  assign num   = NumW'({exp_i, 16'b0}) + NumW'(sum_i >> 1);
  assign trial = {rem_q, sh_q[ProbW-1]};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num[NumW-1 -: SumW];
      sh_d  = num[ProbW-1:0];
      cnt_d = 5'(ProbW);
    end else if (cnt_q != 5'd0) begin
      if (trial >= {1'b0, sum_i}) begin
        rem_d = SumW'(trial - {1'b0, sum_i});
        sh_d  = {sh_q[ProbW-2:0], 1'b1};
      end else begin
        rem_d = trial[SumW-1:0];
        sh_d  = {sh_q[ProbW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule
`default_nettype wire

// ===== design/softmax_vector_unit_top.sv =====
// softmax vector unit top: sample store, exp pass, divide pass, output register
// depends on smx_pkg and smx_divider
// sequence: input beats are accepted while idle; after the last beat, the exp pass runs per
// element (memory read, table multiply, accumulate), then the divide pass runs per result beat
// (memory read, divider load, bit-serial divide, done, output held until accepted)
// reset: async active low clears count, sum and overflow, sets max to minimum; stores need no clearing
`default_nettype none
module softmax_vector_unit_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire smx_pkg::in_t  in_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output smx_pkg::out_t      out_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i
);
  import smx_pkg::*;

  localparam int unsigned IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ERD, ST_EMUL, ST_EWR, ST_DRD, ST_DLD, ST_DWAIT, ST_OUT
  } state_e;

  state_e                    state_q;
  logic [CntW-1:0]           cnt_q;
  logic [IdxW-1:0]           idx_q;
  logic signed [SampleW-1:0] max_q;
  logic [SumW-1:0]           sum_q;
  logic                      ovf_q;
  logic [2*ExpW-1:0]         prod_q;
  out_t                      out_q;

  logic signed [SampleW-1:0] smp_mem [MAX_LEN];
  logic [ExpW-1:0]           exp_mem [MAX_LEN];
  logic signed [SampleW-1:0] smp_rd_q;
  logic [ExpW-1:0]           exp_rd_q;

  logic              in_beat, out_beat, last_idx;
  logic [SampleW:0]  diff;
  logic [SampleW-1:0] m;
  logic [ExpW-1:0]   it_v, ft_v;
  logic [2*ExpW-1:0] prod_r;
  logic [ExpW-1:0]   e_v;
  logic              div_done;
  logic [ProbW-1:0]  quot;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_beat    = out_valid_o && out_ready_i;
  assign out_o       = out_q;
  assign last_idx    = (CntW'(idx_q) + CntW'(1) == cnt_q);

  assign diff = {max_q[SampleW-1], max_q} - {smp_rd_q[SampleW-1], smp_rd_q};
  assign m    = diff[SampleW-1:0];

  always_comb begin
    it_v = '0;
    ft_v = '0;
    if (32'(m) <= ExpLimit) begin
      it_v = IntTab[m[11:8]];
      ft_v = FracTab[m[7:0]];
    end
  end

  assign prod_r = prod_q + (2*ExpW)'(32768);
  assign e_v    = prod_r[16 +: ExpW];

  always_ff @(posedge clk_i) begin
    if (in_beat && CntW'(MAX_LEN) != cnt_q) begin
      smp_mem[cnt_q[IdxW-1:0]] <= in_i.sample;
    end
    if (state_q == ST_EWR) begin
      exp_mem[idx_q] <= e_v;
    end
    smp_rd_q <= smp_mem[idx_q];
    exp_rd_q <= exp_mem[idx_q];
    prod_q   <= it_v * ft_v;
  end

  smx_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DLD),
    .exp_i   (exp_rd_q),
    .sum_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      max_q   <= {1'b1, {(SampleW-1){1'b0}}};
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      out_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (CntW'(MAX_LEN) != cnt_q) begin
              if (cnt_q == '0 || in_i.sample > max_q) begin
                max_q <= in_i.sample;
              end
              cnt_q <= cnt_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.end_of_vector) begin
              idx_q   <= '0;
              sum_q   <= '0;
              state_q <= ST_ERD;
            end
          end
        end
        ST_ERD:  state_q <= ST_EMUL;
        ST_EMUL: state_q <= ST_EWR;
        ST_EWR: begin
          sum_q <= sum_q + SumW'(e_v);
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= ST_DRD;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= ST_ERD;
          end
        end
        ST_DRD: state_q <= ST_DLD;
        ST_DLD: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            out_q.probability  <= quot;
            out_q.position     <= PosW'(idx_q);
            out_q.final_result <= last_idx;
            out_q.truncated    <= ovf_q;
            state_q            <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_beat) begin
            if (last_idx) begin
              cnt_q   <= '0;
              idx_q   <= '0;
              max_q   <= {1'b1, {(SampleW-1){1'b0}}};
              sum_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= ST_DRD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
